// ----- src/zoned_disk_sector_allocator_top_defines.svh -----
// assertion macros for the zoned disk sector allocator checker
// no dependencies; taken in by the checker file
`ifndef ZONED_DISK_SECTOR_ALLOCATOR_TOP_DEFINES_SVH
`define ZONED_DISK_SECTOR_ALLOCATOR_TOP_DEFINES_SVH

// same-cycle implication
`define ZDSA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("zdsa check failed");

// next-cycle implication
`define ZDSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("zdsa check failed");

`endif

// ----- src/zdsa_pkg.sv -----
// package of the zoned disk sector allocator: geometry, codes, types, helpers
// no dependencies; used by the interfaces, the top level and the checker
`timescale 1ns / 1ps
`default_nettype none

package zdsa_pkg;

    localparam int TRACKS_PER_SIDE       = 77;
    localparam int MAX_SECTORS_PER_TRACK = 29;
    localparam int ALL_TRACKS            = 2 * TRACKS_PER_SIDE;
    localparam int BAM_TRK               = 38;
    localparam int DIR_TRK               = 39;

    localparam int ZONE1_LAST    = 39;
    localparam int ZONE2_LAST    = 53;
    localparam int ZONE3_LAST    = 64;
    localparam int ZONE4_LAST    = 77;
    localparam int ZONE1_SECTORS = 29;
    localparam int ZONE2_SECTORS = 27;
    localparam int ZONE3_SECTORS = 25;
    localparam int ZONE4_SECTORS = 23;

    localparam int BAM_USED_A         = 0;
    localparam int BAM_USED_B         = 3;
    localparam int DIR_USED_A         = 0;
    localparam int DIR_USED_B         = 1;
    localparam int SYS_USED_PER_TRACK = 2;

    localparam int CMD_W   = 3;
    localparam int TRK_W   = 8;
    localparam int SEC_W   = 5;
    localparam int TOTAL_W = 13;
    localparam int CNT_W   = 8;
    localparam int ZONE_W  = 6;
    localparam int ADDR_W  = $clog2(ALL_TRACKS);
    localparam int ENTRY_W = CNT_W + MAX_SECTORS_PER_TRACK;

    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_DOUBLE_SIDED = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_QUERY      = 3'd0,
        CMD_ALLOC      = 3'd1,
        CMD_FREE       = 3'd2,
        CMD_ALLOC_NEXT = 3'd3,
        CMD_COUNT      = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_EVAL,
        ST_SCAN,
        ST_FIN
    } t_state;

    typedef struct packed {
        logic [CNT_W-1:0]                 count;
        logic [MAX_SECTORS_PER_TRACK-1:0] bits;
    } t_entry;

    function automatic logic [ZONE_W-1:0] zone_size(input logic [TRK_W-1:0] t);
        logic [TRK_W-1:0]  u;
        logic [ZONE_W-1:0] n;
        u = t;
        if (int'(t) > TRACKS_PER_SIDE) begin
            u = t - TRK_W'(TRACKS_PER_SIDE);
        end
        if (int'(u) >= 1 && int'(u) <= ZONE1_LAST) begin
            n = ZONE_W'(ZONE1_SECTORS);
        end else if (int'(u) > ZONE1_LAST && int'(u) <= ZONE2_LAST) begin
            n = ZONE_W'(ZONE2_SECTORS);
        end else if (int'(u) > ZONE2_LAST && int'(u) <= ZONE3_LAST) begin
            n = ZONE_W'(ZONE3_SECTORS);
        end else if (int'(u) > ZONE3_LAST && int'(u) <= ZONE4_LAST) begin
            n = ZONE_W'(ZONE4_SECTORS);
        end else begin
            n = '0;
        end
        if (int'(n) > MAX_SECTORS_PER_TRACK) begin
            n = ZONE_W'(MAX_SECTORS_PER_TRACK);
        end
        return n;
    endfunction

    function automatic logic [MAX_SECTORS_PER_TRACK-1:0] zone_mask(input logic [TRK_W-1:0] t);
        logic [MAX_SECTORS_PER_TRACK-1:0] m;
        logic [ZONE_W-1:0]                n;
        n = zone_size(t);
        for (int i = 0; i < MAX_SECTORS_PER_TRACK; i++) begin
            m[i] = (i < int'(n));
        end
        return m;
    endfunction

    // formatted contents of a track
    function automatic t_entry reset_entry(input logic [TRK_W-1:0] t);
        t_entry e;
        e = '0;
        if (int'(t) >= 1 && int'(t) <= TRACKS_PER_SIDE) begin
            e.bits  = zone_mask(t);
            e.count = CNT_W'(zone_size(t));
            if (int'(t) == BAM_TRK) begin
                e.bits[BAM_USED_A] = 1'b0;
                e.bits[BAM_USED_B] = 1'b0;
                e.count            = e.count - CNT_W'(SYS_USED_PER_TRACK);
            end else if (int'(t) == DIR_TRK) begin
                e.bits[DIR_USED_A] = 1'b0;
                e.bits[DIR_USED_B] = 1'b0;
                e.count            = e.count - CNT_W'(SYS_USED_PER_TRACK);
            end
        end
        return e;
    endfunction

    function automatic logic [SEC_W-1:0] first_free(input logic [MAX_SECTORS_PER_TRACK-1:0] b);
        logic [SEC_W-1:0] idx;
        idx = '0;
        for (int i = MAX_SECTORS_PER_TRACK - 1; i >= 0; i--) begin
            if (b[i]) begin
                idx = SEC_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [ZONE_W-1:0] count_free(input logic [MAX_SECTORS_PER_TRACK-1:0] b);
        return ZONE_W'($countones(b));
    endfunction

endpackage

`default_nettype wire

// ----- src/zdsa_if.sv -----
// command and result channels of the zoned disk sector allocator
// depends on zdsa_pkg for field widths
`timescale 1ns / 1ps
`default_nettype none

interface zdsa_in_if;
    logic                       valid;
    logic                       ready;
    logic [zdsa_pkg::CMD_W-1:0] cmd;
    logic [zdsa_pkg::TRK_W-1:0] track;
    logic [zdsa_pkg::SEC_W-1:0] sector;

    modport source (output valid, cmd, track, sector, input ready);
    modport sink   (input valid, cmd, track, sector, output ready);
endinterface

interface zdsa_out_if;
    logic                         valid;
    logic                         ready;
    logic                         ok;
    logic [zdsa_pkg::TRK_W-1:0]   found_track;
    logic [zdsa_pkg::SEC_W-1:0]   found_sector;
    logic [zdsa_pkg::TOTAL_W-1:0] free_total;

    modport source (output valid, ok, found_track, found_sector, free_total, input ready);
    modport sink   (input valid, ok, found_track, found_sector, free_total, output ready);
endinterface

`default_nettype wire

// ----- src/zdsa_ram.sv -----
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module zdsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- src/zoned_disk_sector_allocator_top.sv -----
// query, allocate and free pass through start, evaluate and finish; a rejected one goes from start to finish
// allocate-next and count free walk the candidate tracks in the scan state, up to the track limit,
// with tracks 77 or 154: one map read per candidate track on the ram's single read port
// one command at a time; the next is taken the cycle after the word is loaded, even while it waits
// reset (synchronous, active low) clears control and the per-track valid flags,
// so every track reads as formatted at once, with no clearing pass
`timescale 1ns / 1ps
`default_nettype none

module zoned_disk_sector_allocator_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    zdsa_in_if.sink                       i_in,
    zdsa_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [zdsa_pkg::PADDR_W-1:0]  paddr,
    input  logic [zdsa_pkg::PDATA_W-1:0]  pwdata,
    output logic [zdsa_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);

    localparam int MAXS = zdsa_pkg::MAX_SECTORS_PER_TRACK;

    zdsa_pkg::t_state r_state, n_state;

    logic                          r_double_sided;
    logic [zdsa_pkg::CMD_W-1:0]    r_cmd;
    logic [zdsa_pkg::TRK_W-1:0]    r_trk, n_trk;
    logic [zdsa_pkg::SEC_W-1:0]    r_sec;
    logic [zdsa_pkg::TRK_W-1:0]    r_near, n_near;
    logic [zdsa_pkg::TRK_W-1:0]    r_d, n_d;
    logic                          r_side, n_side;
    logic                          r_issue_on, n_issue_on;
    logic                          r_p_valid;
    logic                          r_p_init;
    logic [zdsa_pkg::TRK_W-1:0]    r_p_trk;
    logic [zdsa_pkg::ALL_TRACKS-1:0] r_vb;

    logic                          r_ok, n_ok;
    logic [zdsa_pkg::TRK_W-1:0]    r_ft, n_ft;
    logic [zdsa_pkg::SEC_W-1:0]    r_fs, n_fs;
    logic [zdsa_pkg::TOTAL_W-1:0]  r_total, n_total;

    logic                          r_o_valid, n_o_valid;
    logic                          r_o_ok;
    logic [zdsa_pkg::TRK_W-1:0]    r_o_ft;
    logic [zdsa_pkg::SEC_W-1:0]    r_o_fs;
    logic [zdsa_pkg::TOTAL_W-1:0]  r_o_total;

    logic [zdsa_pkg::TRK_W-1:0]    s_lim;
    logic                          s_accept;
    logic                          s_ts_ok;
    logic [zdsa_pkg::TRK_W:0]      s_cand_t;
    logic                          s_side_ok;
    logic                          s_cand_ok;
    logic                          s_rd_en;
    logic [zdsa_pkg::TRK_W-1:0]    s_rd_trk;
    logic [zdsa_pkg::TRK_W-1:0]    s_rd_idx;
    logic [zdsa_pkg::ADDR_W-1:0]   s_rd_addr;
    logic [zdsa_pkg::TRK_W-1:0]    s_wr_idx;
    logic [zdsa_pkg::ADDR_W-1:0]   s_wr_addr;
    logic [zdsa_pkg::ENTRY_W-1:0]  s_ram_q;
    zdsa_pkg::t_entry              s_cur;
    zdsa_pkg::t_entry              s_wdata;
    logic                          s_we;
    logic [MAXS-1:0]               s_masked;
    logic [zdsa_pkg::SEC_W-1:0]    s_first;
    logic                          s_found;
    logic                          s_scan_end;
    logic                          s_out_load;
    logic [MAXS-1:0]               s_sec_hot;
    logic [MAXS-1:0]               s_first_hot;
    logic                          s_cfg_wr;

    // map store: free bits and free count per track
    zdsa_ram #(
        .WIDTH (zdsa_pkg::ENTRY_W),
        .DEPTH (zdsa_pkg::ALL_TRACKS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (s_wr_addr),
        .i_wdata (s_wdata),
        .i_re    (s_rd_en),
        .i_raddr (s_rd_addr),
        .o_rdata (s_ram_q)
    );

    // configuration port
    assign pready   = 1'b1;
    assign s_cfg_wr = psel && penable && pwrite && pready &&
                      (paddr[2] == zdsa_pkg::REG_DOUBLE_SIDED);
    assign prdata   = (paddr[2] == zdsa_pkg::REG_DOUBLE_SIDED) ?
                      {{(zdsa_pkg::PDATA_W-1){1'b0}}, r_double_sided} : '0;

    assign s_lim    = r_double_sided ? zdsa_pkg::TRK_W'(zdsa_pkg::ALL_TRACKS)
                                     : zdsa_pkg::TRK_W'(zdsa_pkg::TRACKS_PER_SIDE);
    assign s_accept = i_in.valid && i_in.ready;

    // shared decode
    always_comb begin
        s_ts_ok = (r_trk != '0) && (r_trk <= s_lim) &&
                  ({1'b0, r_sec} < zdsa_pkg::zone_size(r_trk));

        if (r_cmd == zdsa_pkg::CMD_COUNT) begin
            s_cand_t  = {1'b0, r_d};
            s_side_ok = 1'b1;
        end else if (!r_side) begin
            s_cand_t  = {1'b0, r_near} - {1'b0, r_d};
            s_side_ok = (r_d < r_near);
        end else begin
            s_cand_t  = {1'b0, r_near} + {1'b0, r_d};
            s_side_ok = 1'b1;
        end
        s_cand_ok = r_issue_on && s_side_ok && (s_cand_t != '0) &&
                    (s_cand_t <= {1'b0, s_lim}) &&
                    (s_cand_t != (zdsa_pkg::TRK_W+1)'(zdsa_pkg::BAM_TRK));

        s_cur       = r_p_init ? zdsa_pkg::reset_entry(r_p_trk) : zdsa_pkg::t_entry'(s_ram_q);
        s_masked    = s_cur.bits & zdsa_pkg::zone_mask(r_p_trk);
        s_first     = zdsa_pkg::first_free(s_masked);
        s_sec_hot   = MAXS'(1) << r_sec;
        s_first_hot = MAXS'(1) << s_first;

        s_found    = (r_state == zdsa_pkg::ST_SCAN) && r_p_valid &&
                     (r_cmd == zdsa_pkg::CMD_ALLOC_NEXT) && (s_masked != '0);
        s_scan_end = !r_issue_on && !r_p_valid;
        s_out_load = (r_state == zdsa_pkg::ST_FIN) && (!r_o_valid || o_out.ready);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            zdsa_pkg::ST_IDLE: begin
                if (s_accept) n_state = zdsa_pkg::ST_START;
            end
            zdsa_pkg::ST_START: begin
                case (r_cmd) inside
                    zdsa_pkg::CMD_QUERY, zdsa_pkg::CMD_ALLOC, zdsa_pkg::CMD_FREE: begin
                        n_state = s_ts_ok ? zdsa_pkg::ST_EVAL : zdsa_pkg::ST_FIN;
                    end
                    zdsa_pkg::CMD_ALLOC_NEXT, zdsa_pkg::CMD_COUNT: begin
                        n_state = zdsa_pkg::ST_SCAN;
                    end
                    default: begin
                        n_state = zdsa_pkg::ST_FIN;
                    end
                endcase
            end
            zdsa_pkg::ST_EVAL: begin
                n_state = zdsa_pkg::ST_FIN;
            end
            zdsa_pkg::ST_SCAN: begin
                if (s_found || s_scan_end) n_state = zdsa_pkg::ST_FIN;
            end
            zdsa_pkg::ST_FIN: begin
                if (s_out_load) n_state = zdsa_pkg::ST_IDLE;
            end
            default: begin
                n_state = zdsa_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        n_trk      = r_trk;
        n_near     = r_near;
        n_d        = r_d;
        n_side     = r_side;
        n_issue_on = r_issue_on;
        n_ok       = r_ok;
        n_ft       = r_ft;
        n_fs       = r_fs;
        n_total    = r_total;
        s_rd_en    = 1'b0;
        s_rd_trk   = r_trk;
        s_we       = 1'b0;
        s_wdata    = s_cur;

        unique case (r_state)
            zdsa_pkg::ST_IDLE: begin
                n_issue_on = 1'b0;
            end
            zdsa_pkg::ST_START: begin
                n_ok    = 1'b0;
                n_ft    = '0;
                n_fs    = '0;
                n_total = '0;
                n_side  = 1'b0;
                n_near  = (r_trk == '0) ? zdsa_pkg::TRK_W'(zdsa_pkg::DIR_TRK) : r_trk;
                case (r_cmd) inside
                    zdsa_pkg::CMD_QUERY, zdsa_pkg::CMD_ALLOC, zdsa_pkg::CMD_FREE: begin
                        s_rd_en  = s_ts_ok;
                        s_rd_trk = r_trk;
                    end
                    zdsa_pkg::CMD_ALLOC_NEXT: begin
                        n_d        = '0;
                        n_issue_on = 1'b1;
                    end
                    zdsa_pkg::CMD_COUNT: begin
                        n_d        = zdsa_pkg::TRK_W'(1);
                        n_issue_on = 1'b1;
                        n_ok       = 1'b1;
                    end
                    default: begin
                        n_issue_on = 1'b0;
                    end
                endcase
            end
            zdsa_pkg::ST_EVAL: begin
                case (r_cmd) inside
                    zdsa_pkg::CMD_QUERY: begin
                        n_ok = s_cur.bits[r_sec];
                    end
                    zdsa_pkg::CMD_ALLOC: begin
                        n_ok          = s_cur.bits[r_sec];
                        s_we          = s_cur.bits[r_sec];
                        s_wdata.bits  = s_cur.bits & ~s_sec_hot;
                        s_wdata.count = s_cur.count - zdsa_pkg::CNT_W'(1);
                    end
                    zdsa_pkg::CMD_FREE: begin
                        n_ok          = 1'b1;
                        s_we          = 1'b1;
                        s_wdata.bits  = s_cur.bits | s_sec_hot;
                        s_wdata.count = s_cur.count + zdsa_pkg::CNT_W'(1);
                    end
                    default: begin
                        n_ok = 1'b0;
                    end
                endcase
            end
            zdsa_pkg::ST_SCAN: begin
                // issue the next candidate track
                s_rd_en  = s_cand_ok && !s_found;
                s_rd_trk = s_cand_t[zdsa_pkg::TRK_W-1:0];
                if (r_issue_on) begin
                    if (r_cmd == zdsa_pkg::CMD_COUNT || r_side) begin
                        if (r_d == s_lim) begin
                            n_issue_on = 1'b0;
                        end else begin
                            n_d = r_d + zdsa_pkg::TRK_W'(1);
                        end
                        n_side = 1'b0;
                    end else begin
                        n_side = 1'b1;
                    end
                end
                // evaluate the track read last cycle
                if (s_found) begin
                    n_ok          = 1'b1;
                    n_ft          = r_p_trk;
                    n_fs          = s_first;
                    n_issue_on    = 1'b0;
                    s_we          = 1'b1;
                    s_wdata.bits  = s_cur.bits & ~s_first_hot;
                    s_wdata.count = s_cur.count - zdsa_pkg::CNT_W'(1);
                end else if (r_p_valid && r_cmd == zdsa_pkg::CMD_COUNT) begin
                    n_total = r_total + zdsa_pkg::TOTAL_W'(zdsa_pkg::count_free(s_masked));
                end
            end
            zdsa_pkg::ST_FIN: begin
                n_issue_on = 1'b0;
            end
            default: begin
                n_issue_on = 1'b0;
            end
        endcase

        if (s_out_load) begin
            n_o_valid = 1'b1;
        end else if (o_out.ready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    assign s_rd_idx  = s_rd_trk - zdsa_pkg::TRK_W'(1);
    assign s_rd_addr = s_rd_idx[zdsa_pkg::ADDR_W-1:0];
    assign s_wr_idx  = r_p_trk - zdsa_pkg::TRK_W'(1);
    assign s_wr_addr = s_wr_idx[zdsa_pkg::ADDR_W-1:0];

    assign i_in.ready         = (r_state == zdsa_pkg::ST_IDLE);
    assign o_out.valid        = r_o_valid;
    assign o_out.ok           = r_o_ok;
    assign o_out.found_track  = r_o_ft;
    assign o_out.found_sector = r_o_fs;
    assign o_out.free_total   = r_o_total;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= zdsa_pkg::ST_IDLE;
            r_double_sided <= 1'b0;
            r_issue_on     <= 1'b0;
            r_p_valid      <= 1'b0;
            r_o_valid      <= 1'b0;
            r_vb           <= '0;
        end else begin
            r_state    <= n_state;
            r_issue_on <= n_issue_on;
            r_p_valid  <= s_rd_en;
            r_o_valid  <= n_o_valid;
            if (s_cfg_wr) begin
                r_double_sided <= pwdata[0];
            end
            if (s_we) begin
                r_vb[s_wr_addr] <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_cmd <= i_in.cmd;
            r_trk <= i_in.track;
            r_sec <= i_in.sector;
        end else begin
            r_trk <= n_trk;
        end
        r_near  <= n_near;
        r_d     <= n_d;
        r_side  <= n_side;
        r_ok    <= n_ok;
        r_ft    <= n_ft;
        r_fs    <= n_fs;
        r_total <= n_total;
        if (s_rd_en) begin
            r_p_trk  <= s_rd_trk;
            r_p_init <= !r_vb[s_rd_addr];
        end
        if (s_out_load) begin
            r_o_ok    <= r_ok;
            r_o_ft    <= r_ft;
            r_o_fs    <= r_fs;
            r_o_total <= r_total;
        end
    end

endmodule

`default_nettype wire

// ----- src/zdsa_checker.sv -----
// port-level checks on the result channel of the zoned disk sector allocator
// depends on zdsa_pkg and zoned_disk_sector_allocator_top_defines.svh; bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "zoned_disk_sector_allocator_top_defines.svh"

module zdsa_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_valid,
    input logic                         i_ready,
    input logic                         i_ok,
    input logic [zdsa_pkg::TRK_W-1:0]   i_found_track,
    input logic [zdsa_pkg::SEC_W-1:0]   i_found_sector,
    input logic [zdsa_pkg::TOTAL_W-1:0] i_free_total
);

    // a stalled word holds
    `ZDSA_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_valid && !i_ready, i_valid && $stable(i_ok) && $stable(i_found_track) && $stable(i_found_sector) && $stable(i_free_total))

    // a failed command carries no location
    `ZDSA_ASSERT_IMPL(a_fail_zero, i_clk, i_rst_n, i_valid && !i_ok, i_found_track == '0 && i_found_sector == '0)

    // a found sector lies on a real track off the map track
    `ZDSA_ASSERT_IMPL(a_found_range, i_clk, i_rst_n, i_valid && i_found_track != '0, i_ok && int'(i_found_track) <= zdsa_pkg::ALL_TRACKS && int'(i_found_track) != zdsa_pkg::BAM_TRK && int'(i_found_sector) < zdsa_pkg::MAX_SECTORS_PER_TRACK)

    // a count result carries no location
    `ZDSA_ASSERT_IMPL(a_total_alone, i_clk, i_rst_n, i_valid && i_free_total != '0, i_ok && i_found_track == '0 && i_found_sector == '0)

endmodule

bind zoned_disk_sector_allocator_top zdsa_checker u_zdsa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_out.valid),
    .i_ready        (o_out.ready),
    .i_ok           (o_out.ok),
    .i_found_track  (o_out.found_track),
    .i_found_sector (o_out.found_sector),
    .i_free_total   (o_out.free_total)
);

`default_nettype wire

// ----- tb/tb.sv -----
// testbench for zoned_disk_sector_allocator_top: command words in, one result word out each
// depends on zdsa_pkg and the zdsa_in_if / zdsa_out_if interfaces of the design
// self-checking against an internal model of the free map, with configuration over apb
`timescale 1ns / 1ps

module tb;
    import zdsa_pkg::*;

    localparam int HOLD_CYCLES = 600;
    localparam int SETTLE      = 8;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    typedef struct packed {
        logic               ok;
        logic [TRK_W-1:0]   found_track;
        logic [SEC_W-1:0]   found_sector;
        logic [TOTAL_W-1:0] free_total;
    } t_alloc_word;

    class alloc_scoreboard;
        logic [MAX_SECTORS_PER_TRACK-1:0] free_map [1:ALL_TRACKS];
        logic [CNT_W-1:0]                 free_cnt [1:ALL_TRACKS];
        bit                               two_sides;
        t_alloc_word                      want_q [$];
        int                               errors;
        int                               checked;
        logic [TRK_W-1:0]                 last_trk;
        logic [SEC_W-1:0]                 last_sec;

        function new();
            int n;
            two_sides = 1'b0;
            errors    = 0;
            checked   = 0;
            last_trk  = '0;
            last_sec  = '0;
            for (int t = 1; t <= ALL_TRACKS; t++) begin
                free_map[t] = '0;
                free_cnt[t] = '0;
            end
            for (int t = 1; t <= TRACKS_PER_SIDE; t++) begin
                n = sectors_on(t);
                for (int s = 0; s < n; s++) free_map[t][s] = 1'b1;
                free_cnt[t] = CNT_W'(n);
            end
            void'(grab(BAM_TRK, BAM_USED_A));
            void'(grab(BAM_TRK, BAM_USED_B));
            void'(grab(DIR_TRK, DIR_USED_A));
            void'(grab(DIR_TRK, DIR_USED_B));
        endfunction

        function int sectors_on(int t);
            int u;
            int n;
            u = (t > TRACKS_PER_SIDE) ? t - TRACKS_PER_SIDE : t;
            if (u >= 1 && u <= ZONE1_LAST) n = ZONE1_SECTORS;
            else if (u > ZONE1_LAST && u <= ZONE2_LAST) n = ZONE2_SECTORS;
            else if (u > ZONE2_LAST && u <= ZONE3_LAST) n = ZONE3_SECTORS;
            else if (u > ZONE3_LAST && u <= ZONE4_LAST) n = ZONE4_SECTORS;
            else n = 0;
            if (n > MAX_SECTORS_PER_TRACK) n = MAX_SECTORS_PER_TRACK;
            return n;
        endfunction

        function int tracks_now();
            return two_sides ? ALL_TRACKS : TRACKS_PER_SIDE;
        endfunction

        function bit usable(int t, int s);
            if (t < 1 || t > tracks_now()) return 1'b0;
            return s < sectors_on(t);
        endfunction

        function bit grab(int t, int s);
            if (!usable(t, s)) return 1'b0;
            if (!free_map[t][s]) return 1'b0;
            free_map[t][s] = 1'b0;
            free_cnt[t]    = free_cnt[t] - 1'b1;
            return 1'b1;
        endfunction

        function int pending();
            return want_q.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= 40) $display("tb: mismatch at %0t: %s", $time, msg);
        endtask

        function void note_cmd(logic [CMD_W-1:0] c, logic [TRK_W-1:0] trk,
                               logic [SEC_W-1:0] sec);
            t_alloc_word w;
            int          t;
            int          s;
            int          lim;
            int          near;
            int          tt;
            int          n;
            int          total;
            bit          done;
            w     = '0;
            t     = int'(trk);
            s     = int'(sec);
            lim   = tracks_now();
            total = 0;
            done  = 1'b0;
            case (c)
                CMD_QUERY: begin
                    w.ok = usable(t, s) ? free_map[t][s] : 1'b0;
                end
                CMD_ALLOC: begin
                    w.ok = grab(t, s);
                end
                CMD_FREE: begin
                    if (usable(t, s)) begin
                        free_map[t][s] = 1'b1;
                        free_cnt[t]    = free_cnt[t] + 1'b1;
                        w.ok           = 1'b1;
                    end
                end
                CMD_ALLOC_NEXT: begin
                    near = (t < 1) ? DIR_TRK : t;
                    for (int d = 0; d <= lim && !done; d++) begin
                        for (int side = 0; side < 2 && !done; side++) begin
                            if (side == 0) begin
                                if (d >= near) continue;
                                tt = near - d;
                            end else begin
                                tt = near + d;
                            end
                            if (tt < 1 || tt > lim || tt == BAM_TRK) continue;
                            n = sectors_on(tt);
                            for (int ss = 0; ss < n && !done; ss++) begin
                                if (free_map[tt][ss]) begin
                                    void'(grab(tt, ss));
                                    w.ok           = 1'b1;
                                    w.found_track  = TRK_W'(tt);
                                    w.found_sector = SEC_W'(ss);
                                    last_trk       = TRK_W'(tt);
                                    last_sec       = SEC_W'(ss);
                                    done           = 1'b1;
                                end
                            end
                        end
                    end
                end
                CMD_COUNT: begin
                    for (int k = 1; k <= lim; k++) begin
                        if (k == BAM_TRK) continue;
                        n = sectors_on(k);
                        for (int ss = 0; ss < n; ss++) if (free_map[k][ss]) total++;
                    end
                    w.free_total = TOTAL_W'(total);
                    w.ok         = 1'b1;
                end
                default: begin
                end
            endcase
            want_q.insert(want_q.size(), w);
        endfunction

        task check_word(t_alloc_word got);
            t_alloc_word want;
            if (want_q.size() == 0) begin
                report("result word with no command outstanding");
            end else begin
                want = want_q.pop_front();
                checked++;
                if (got.ok !== want.ok)
                    report($sformatf("ok got %0d want %0d", got.ok, want.ok));
                if (got.found_track !== want.found_track)
                    report($sformatf("found_track got %0d want %0d",
                                     got.found_track, want.found_track));
                if (got.found_sector !== want.found_sector)
                    report($sformatf("found_sector got %0d want %0d",
                                     got.found_sector, want.found_sector));
                if (got.free_total !== want.free_total)
                    report($sformatf("free_total got %0d want %0d",
                                     got.free_total, want.free_total));
            end
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    zdsa_in_if  cmd_ch ();
    zdsa_out_if res_ch ();

    alloc_scoreboard sb = new();
    t_idle_mode      idle_mode = IDLE_NONE;
    int              hold_asked = 0;
    int              hold_served = 0;
    int              n_sent = 0;
    int              n_next = 0;
    int              n_count = 0;

    zoned_disk_sector_allocator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_ch),
        .o_out   (res_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // result side: random stalls, plus a long hold-off on request
    initial begin : result_sink
        int held;
        res_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_served) begin
                res_ch.ready <= 1'b0;
                for (held = 1; held < HOLD_CYCLES; held++) @(posedge i_clk);
                hold_served++;
            end else if (idle_mode == IDLE_RECV) begin
                res_ch.ready <= ($urandom_range(0, 99) >= 73);
            end else if (idle_mode == IDLE_BOTH) begin
                res_ch.ready <= ($urandom_range(0, 99) >= 11);
            end else begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_ch.valid && res_ch.ready) begin
            sb.check_word({res_ch.ok, res_ch.found_track, res_ch.found_sector,
                           res_ch.free_total});
        end
    end

    task automatic send_cmd(input logic [CMD_W-1:0] c, input logic [TRK_W-1:0] t,
                            input logic [SEC_W-1:0] s);
        int pct;
        pct = (idle_mode == IDLE_SEND) ? 73 : (idle_mode == IDLE_BOTH) ? 11 : 0;
        while ($urandom_range(0, 99) < pct) begin
            cmd_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.cmd    <= c;
        cmd_ch.track  <= t;
        cmd_ch.sector <= s;
        @(posedge i_clk);
        while (!cmd_ch.ready) @(posedge i_clk);
        sb.note_cmd(c, t, s);
        n_sent++;
        if (c == CMD_ALLOC_NEXT) n_next++;
        if (c == CMD_COUNT) n_count++;
    endtask

    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_sides(input logic v);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(4 * int'(REG_DOUBLE_SIDED));
        pwdata  <= PDATA_W'(v);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel      <= 1'b0;
        penable   <= 1'b0;
        pwrite    <= 1'b0;
        sb.two_sides = v;
    endtask

    task automatic random_cmds(input int count);
        logic [CMD_W-1:0] c;
        logic [TRK_W-1:0] t;
        logic [SEC_W-1:0] s;
        int               r;
        int               n;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(0, 99);
            if (r < 20) c = CMD_QUERY;
            else if (r < 40) c = CMD_ALLOC;
            else if (r < 55) c = CMD_FREE;
            else if (r < 87) c = CMD_ALLOC_NEXT;
            else if (r < 96) c = CMD_COUNT;
            else c = CMD_W'($urandom_range(5, 7));
            r = $urandom_range(0, 99);
            if (r < 80) t = TRK_W'($urandom_range(1, sb.tracks_now()));
            else if (r < 92) t = TRK_W'($urandom_range(0, 255));
            else begin
                case ($urandom_range(0, 7))
                    0: t = '0;
                    1: t = TRK_W'(BAM_TRK);
                    2: t = TRK_W'(DIR_TRK);
                    3: t = TRK_W'(TRACKS_PER_SIDE);
                    4: t = TRK_W'(TRACKS_PER_SIDE + 1);
                    5: t = TRK_W'(ALL_TRACKS);
                    6: t = TRK_W'(ALL_TRACKS + 1);
                    default: t = '1;
                endcase
            end
            n = sb.sectors_on(int'(t));
            if ($urandom_range(0, 99) < 85 && n > 0) s = SEC_W'($urandom_range(0, n - 1));
            else s = SEC_W'($urandom_range(0, 31));
            // give back what the last search handed out
            if (c == CMD_FREE && $urandom_range(0, 99) < 30) begin
                t = sb.last_trk;
                s = sb.last_sec;
            end
            send_cmd(c, t, s);
        end
    endtask

    initial begin
        #50_000_000;
        $display("tb: failure");
        $finish;
    end

    initial begin
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.cmd    <= '0;
        cmd_ch.track  <= '0;
        cmd_ch.sector <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        write_sides(1'b0);

        // directed: system sectors, bounds, zone edges, searches, unknown commands
        send_cmd(CMD_QUERY, 8'd38, 5'd0);
        send_cmd(CMD_QUERY, 8'd38, 5'd1);
        send_cmd(CMD_QUERY, 8'd39, 5'd1);
        send_cmd(CMD_COUNT, 8'd0, 5'd0);
        send_cmd(CMD_ALLOC, 8'd38, 5'd0);
        send_cmd(CMD_ALLOC, 8'd1, 5'd0);
        send_cmd(CMD_ALLOC, 8'd1, 5'd0);
        send_cmd(CMD_FREE, 8'd1, 5'd0);
        send_cmd(CMD_FREE, 8'd1, 5'd0);
        send_cmd(CMD_QUERY, 8'd0, 5'd0);
        send_cmd(CMD_QUERY, 8'd78, 5'd0);
        send_cmd(CMD_ALLOC, 8'd255, 5'd31);
        send_cmd(CMD_QUERY, 8'd40, 5'd26);
        send_cmd(CMD_QUERY, 8'd40, 5'd27);
        send_cmd(CMD_ALLOC, 8'd77, 5'd22);
        send_cmd(CMD_FREE, 8'd77, 5'd23);
        send_cmd(CMD_ALLOC_NEXT, 8'd0, 5'd0);
        send_cmd(CMD_ALLOC_NEXT, 8'd38, 5'd0);
        send_cmd(CMD_ALLOC_NEXT, 8'd1, 5'd0);
        send_cmd(CMD_ALLOC_NEXT, 8'd77, 5'd31);
        send_cmd(CMD_ALLOC_NEXT, 8'd155, 5'd0);
        send_cmd(CMD_ALLOC_NEXT, 8'd255, 5'd0);
        send_cmd(CMD_W'(5), 8'd255, 5'd31);
        send_cmd(CMD_W'(7), 8'd1, 5'd0);
        send_cmd(CMD_COUNT, 8'd0, 5'd0);
        settle();

        // output held off while commands keep coming
        hold_asked++;
        random_cmds(300);
        settle();

        write_sides(1'b1);
        idle_mode = IDLE_SEND;
        random_cmds(400);
        settle();

        idle_mode = IDLE_RECV;
        random_cmds(400);
        settle();

        write_sides(1'b0);
        idle_mode = IDLE_BOTH;
        random_cmds(350);
        settle();

        write_sides(1'b1);
        idle_mode = IDLE_NONE;
        random_cmds(350);
        settle();

        if (sb.pending() != 0) sb.report("commands left without a result word");
        $display("tb: %0d commands sent, %0d allocate-next and %0d count-free among them",
                 n_sent, n_next, n_count);
        $display("tb: %0d words checked over one- and two-sided maps, all idling patterns",
                 sb.checked);
        if (sb.errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
